FILE: rtl/mip_chain_buffer_offset_unit_assert.svh
// Assertion macros for the mip chain offset unit.
// Each macro takes a label, the clock, the reset, a condition and a check.
`ifndef MIP_CHAIN_BUFFER_OFFSET_UNIT_ASSERT_SVH
`define MIP_CHAIN_BUFFER_OFFSET_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// check holds in the same cycle as the condition
`define MCBO_ASSERT_IMP(lbl, ck, rs, cond, chk) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |-> (chk)) \
    else $error("mcbo assertion failed");

// check holds in the cycle after the condition
`define MCBO_ASSERT_NXT(lbl, ck, rs, cond, chk) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |=> (chk)) \
    else $error("mcbo assertion failed");

`else

`define MCBO_ASSERT_IMP(lbl, ck, rs, cond, chk)
`define MCBO_ASSERT_NXT(lbl, ck, rs, cond, chk)

`endif

`endif

FILE: rtl/mcbo_pkg.sv
package mcbo_pkg;

  // field widths
  localparam int DIM_W      = 15;
  localparam int DEPTH_W    = 12;
  localparam int BPP_W      = 5;
  localparam int MIP_W      = 4;
  localparam int LAYER_W    = 11;
  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // levels stored per layer at most
  localparam int MAX_MIP_LEVELS = 15;

  // shared multiplier: 42-bit operand covers w*h*d, 15-bit covers a dimension
  localparam int MUL_A_W = 42;
  localparam int MUL_B_W = 15;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_WIDTH  = 3'd0,
    REG_BASE_HEIGHT = 3'd1,
    REG_BASE_DEPTH  = 3'd2,
    REG_BPP         = 3'd3,
    REG_MIP_COUNT   = 3'd4
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WH,     // width * height
    ST_D,      // * depth
    ST_B,      // * bytes per pixel
    ST_ACC,    // fold in last level size
    ST_LAYER,  // layer * chain bytes
    ST_FINAL   // offset add, result register load
  } state_t;

  // level dimension: base >> level, floor of one
  function automatic logic [DIM_W-1:0] level_dim(input logic [DIM_W-1:0] base,
                                                 input logic [MIP_W-1:0] lvl);
    logic [DIM_W-1:0] v;
    v = base >> lvl;
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

endpackage

FILE: rtl/mcbo_mul.sv
// Shared multiplier with registered product.
module mcbo_mul import mcbo_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

FILE: rtl/mip_chain_buffer_offset_unit.sv
// Mip chain buffer offset unit. Locates one (layer, mip level) pair in a buffer
// whose layers each hold a packed chain of mip levels, and returns the level's
// dimensions, its byte size, the byte offset and a 32-bit wrap flag. One
// multiplier is shared: each level takes three passes (w*h, *depth, *bytes per
// pixel), levels are walked from zero up to L = max(mip_index,
// mip_count - 1 when layer_index > 0), then ST_ACC folds the last size in,
// ST_LAYER multiplies by the layer and ST_FINAL forms the offset; ST_FINAL
// waits while an earlier result sits stalled in the output register.
// The input is stalled while an item is in work; a finished result waits in the
// output register, so the next item can be taken while it is still unread.
// Configuration writes are always ready and must only be issued when idle.
`include "mip_chain_buffer_offset_unit_assert.svh"

module mip_chain_buffer_offset_unit import mcbo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LAYER_W-1:0]    layer_index,
  input  logic [MIP_W-1:0]      mip_index,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIM_W-1:0]      level_width,
  output logic [DIM_W-1:0]      level_height,
  output logic [DEPTH_W-1:0]    level_depth,
  output logic [WORD_W-1:0]     level_bytes,
  output logic [WORD_W-1:0]     byte_offset,
  output logic                  overflow,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [DIM_W-1:0]   base_width;
  logic [DIM_W-1:0]   base_height;
  logic [DEPTH_W-1:0] base_depth;
  logic [BPP_W-1:0]   bytes_per_pixel;
  logic [MIP_W-1:0]   mip_count;

  // sequencer and datapath state
  state_t             state, state_next;
  logic [MIP_W-1:0]   lvl;
  logic [LAYER_W-1:0] layer_q;
  logic [MIP_W-1:0]   mip_q;
  logic [WORD_W-1:0]  chain;
  logic [WORD_W-1:0]  low_sum;
  logic [WORD_W-1:0]  lvl_bytes_q;
  logic               ovf_acc;

  // multiplier hookup
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic               in_take;
  logic               acc_en;
  logic               out_load;
  logic [MIP_W-1:0]   n_lvl;
  logic [MIP_W-1:0]   last_lvl;
  logic [MIP_W-1:0]   acc_lvl;
  logic               layer_nz;
  logic               prod_big;
  logic [WORD_W:0]    chain_sum;
  logic [WORD_W:0]    low_sum_add;
  logic [WORD_W:0]    off_sum;
  logic               ovf_set;
  logic [DIM_W-1:0]   dim_w, dim_h, dim_d;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_width      <= DIM_W'(1);
      base_height     <= DIM_W'(1);
      base_depth      <= DEPTH_W'(1);
      bytes_per_pixel <= BPP_W'(4);
      mip_count       <= MIP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_WIDTH:  base_width      <= cfg_data;
        REG_BASE_HEIGHT: base_height     <= cfg_data;
        REG_BASE_DEPTH:  base_depth      <= cfg_data[DEPTH_W-1:0];
        REG_BPP:         bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_MIP_COUNT:   mip_count       <= cfg_data[MIP_W-1:0];
        default: ;
      endcase
    end
  end

  // loop bounds
  assign layer_nz = (layer_q != '0);
  assign n_lvl    = (mip_count > MIP_W'(MAX_MIP_LEVELS)) ? MIP_W'(MAX_MIP_LEVELS)
                                                          : mip_count;
  always_comb begin
    last_lvl = mip_q;
    if (layer_nz && (n_lvl != '0) && ((n_lvl - 1'b1) > mip_q)) begin
      last_lvl = n_lvl - 1'b1;
    end
  end

  // level dimensions for the level in work
  assign dim_w = level_dim(base_width, lvl);
  assign dim_h = level_dim(base_height, lvl);
  assign dim_d = level_dim(DIM_W'(base_depth), lvl);

  // size of the previous level is folded in while the next one multiplies
  assign acc_lvl     = (state == ST_ACC) ? lvl : lvl - 1'b1;
  assign prod_big    = |prod[PROD_W-1:WORD_W];
  assign chain_sum   = {1'b0, chain} + {1'b0, prod[WORD_W-1:0]};
  assign low_sum_add = {1'b0, low_sum} + {1'b0, prod[WORD_W-1:0]};
  assign off_sum     = {1'b0, prod[WORD_W-1:0]} + {1'b0, low_sum};

  always_comb begin
    ovf_set = 1'b0;
    if (state == ST_B) begin
      ovf_set = prod_big;  // w*h*d past 32 bits
    end
    if (acc_en) begin
      ovf_set = prod_big
              || (layer_nz && (acc_lvl < n_lvl) && chain_sum[WORD_W])
              || ((acc_lvl < mip_q) && low_sum_add[WORD_W]);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    acc_en     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_WH;
        end
      end
      ST_WH: begin
        mul_en     = 1'b1;
        mul_a      = MUL_A_W'(dim_w);
        mul_b      = dim_h;
        acc_en     = (lvl != '0);
        state_next = ST_D;
      end
      ST_D: begin
        mul_en     = 1'b1;
        mul_a      = prod[MUL_A_W-1:0];
        mul_b      = dim_d;
        state_next = ST_B;
      end
      ST_B: begin
        mul_en     = 1'b1;
        mul_a      = prod[MUL_A_W-1:0];
        mul_b      = MUL_B_W'(bytes_per_pixel);
        state_next = (lvl == last_lvl) ? ST_ACC : ST_WH;
      end
      ST_ACC: begin
        acc_en     = 1'b1;
        state_next = ST_LAYER;
      end
      ST_LAYER: begin
        mul_en     = 1'b1;
        mul_a      = MUL_A_W'(chain);
        mul_b      = MUL_B_W'(layer_q);
        state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  mcbo_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // accumulators and level counter
  always_ff @(posedge clk) begin
    if (in_take) begin
      layer_q <= layer_index;
      mip_q   <= mip_index;
      lvl     <= '0;
      chain   <= '0;
      low_sum <= '0;
      ovf_acc <= 1'b0;
    end else begin
      ovf_acc <= ovf_acc | ovf_set;
      if ((state == ST_B) && (lvl != last_lvl)) begin
        lvl <= lvl + 1'b1;
      end
      if (acc_en) begin
        if (layer_nz && (acc_lvl < n_lvl)) begin
          chain <= chain_sum[WORD_W-1:0];
        end
        if (acc_lvl < mip_q) begin
          low_sum <= low_sum_add[WORD_W-1:0];
        end
        if (acc_lvl == mip_q) begin
          lvl_bytes_q <= prod[WORD_W-1:0];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      level_width  <= level_dim(base_width, mip_q);
      level_height <= level_dim(base_height, mip_q);
      level_depth  <= DEPTH_W'(level_dim(DIM_W'(base_depth), mip_q));
      level_bytes  <= lvl_bytes_q;
      byte_offset  <= off_sum[WORD_W-1:0];
      overflow     <= ovf_acc | prod_big | off_sum[WORD_W];
    end
  end

  // checks
  `MCBO_ASSERT_NXT(a_accept_starts, clk, rst, in_take, (state == ST_WH) && (lvl == '0))
  `MCBO_ASSERT_IMP(a_lvl_bound, clk, rst, state == ST_B, lvl <= last_lvl)
  `MCBO_ASSERT_IMP(a_chain_zero, clk, rst, (state != ST_IDLE) && !layer_nz, chain == '0)
  `MCBO_ASSERT_IMP(a_dims_nonzero, clk, rst, out_valid, (level_width != '0) && (level_height != '0) && (level_depth != '0))

endmodule

FILE: dv/tb_mip_chain_buffer_offset_unit.sv
module tb_mip_chain_buffer_offset_unit;
  import mcbo_pkg::*;

  // unmapped register indexes; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
  localparam logic [63:0] WORD_LIMIT = 64'hFFFF_FFFF;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD = 300;

  logic clk;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [LAYER_W-1:0]    layer_index = '0;
  logic [MIP_W-1:0]      mip_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DIM_W-1:0]      level_width;
  logic [DIM_W-1:0]      level_height;
  logic [DEPTH_W-1:0]    level_depth;
  logic [WORD_W-1:0]     level_bytes;
  logic [WORD_W-1:0]     byte_offset;
  logic                  overflow;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mip_chain_buffer_offset_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .layer_index(layer_index), .mip_index(mip_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .level_width(level_width), .level_height(level_height), .level_depth(level_depth),
    .level_bytes(level_bytes), .byte_offset(byte_offset), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // one lookup request or one register write
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [LAYER_W-1:0]    layer;
    logic [MIP_W-1:0]      mip;
    int unsigned           gap;
  } request_t;

  typedef struct {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [DEPTH_W-1:0] depth;
    logic [WORD_W-1:0]  bytes;
    logic [WORD_W-1:0]  offset;
    logic               ovf;
  } level_loc_t;

  typedef struct {
    logic [WORD_W-1:0] bytes;
    bit                ovf;
  } level_size_t;

  request_t   pending_requests[$];
  level_loc_t expected_locations[$];

  // shadow copy of the configuration registers
  logic [DIM_W-1:0]   tex_width;
  logic [DIM_W-1:0]   tex_height;
  logic [DEPTH_W-1:0] tex_depth;
  logic [BPP_W-1:0]   tex_bpp;
  logic [MIP_W-1:0]   tex_mips;

  int unsigned n_errors = 0;
  int unsigned n_queued = 0;
  int unsigned n_received = 0;

  // driver state
  request_t    cur_req;
  bit          have_req = 0;
  int unsigned gap_left = 0;
  int unsigned settle_left = 0;
  bit          offer_item;
  bit          offer_write;

  // monitor state
  int unsigned stall_left = 0;
  level_loc_t  want;

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic add_item(input int unsigned layer, input int unsigned mip);
    request_t r;
    r.is_write = 0;
    r.idx = '0;
    r.data = '0;
    r.layer = LAYER_W'(layer);
    r.mip = MIP_W'(mip);
    r.gap = ((n_queued / 40) % 3 == 1) ? 0 : $urandom_range(0, 5);
    pending_requests.push_back(r);
    n_queued++;
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    request_t r;
    r.is_write = 1;
    r.idx = idx;
    r.data = CFG_DATA_W'(data);
    r.layer = '0;
    r.mip = '0;
    r.gap = 0;
    pending_requests.push_back(r);
  endtask

  // dimension of a mip level, never below one
  function automatic logic [DIM_W-1:0] shrink_dim(input logic [DIM_W-1:0] base,
                                                  input logic [MIP_W-1:0] lvl);
    logic [DIM_W-1:0] v;
    v = base >> lvl;
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

  // byte size of one level with the 32-bit wrap flag
  function automatic level_size_t size_of_level(input logic [MIP_W-1:0] lvl);
    level_size_t s;
    logic [63:0] whd;
    logic [63:0] total;
    whd = 64'(shrink_dim(tex_width, lvl)) * 64'(shrink_dim(tex_height, lvl));
    whd = whd * 64'(shrink_dim(DIM_W'(tex_depth), lvl));
    total = whd * 64'(tex_bpp);
    s.bytes = total[31:0];
    s.ovf = (whd > WORD_LIMIT) || (total > WORD_LIMIT);
    return s;
  endfunction

  // expected dimensions, size and buffer offset of one (layer, level) pair
  function automatic level_loc_t locate_level(input logic [LAYER_W-1:0] layer,
                                              input logic [MIP_W-1:0] mip);
    level_loc_t  r;
    level_size_t s;
    logic [WORD_W-1:0] chain;
    logic [WORD_W-1:0] offset;
    logic [WORD_W:0]   sum;
    logic [63:0]       prod;
    logic [DIM_W-1:0]  d;
    bit ovf;
    int n;
    ovf = 0;
    offset = '0;
    if (layer != '0) begin
      chain = '0;
      n = (tex_mips < MAX_MIP_LEVELS) ? int'(tex_mips) : MAX_MIP_LEVELS;
      for (int i = 0; i < n; i++) begin
        s = size_of_level(MIP_W'(i));
        sum = {1'b0, chain} + {1'b0, s.bytes};
        ovf = ovf | s.ovf | sum[WORD_W];
        chain = sum[WORD_W-1:0];
      end
      prod = 64'(layer) * 64'(chain);
      if (prod > WORD_LIMIT) ovf = 1;
      offset = prod[31:0];
    end
    // levels below the requested one, stored or not
    for (int i = 0; i < int'(mip); i++) begin
      s = size_of_level(MIP_W'(i));
      sum = {1'b0, offset} + {1'b0, s.bytes};
      ovf = ovf | s.ovf | sum[WORD_W];
      offset = sum[WORD_W-1:0];
    end
    s = size_of_level(mip);
    ovf = ovf | s.ovf;
    d = shrink_dim(DIM_W'(tex_depth), mip);
    r.width = shrink_dim(tex_width, mip);
    r.height = shrink_dim(tex_height, mip);
    r.depth = DEPTH_W'(d);
    r.bytes = s.bytes;
    r.offset = offset;
    r.ovf = ovf;
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver: lookups and register writes, one transaction at a time
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      layer_index <= '0;
      mip_index <= '0;
      cfg_index <= '0;
      cfg_data <= '0;
      have_req = 0;
      tex_width = DIM_W'(1);
      tex_height = DIM_W'(1);
      tex_depth = DEPTH_W'(1);
      tex_bpp = BPP_W'(4);
      tex_mips = MIP_W'(1);
    end else begin
      if (in_valid && !in_stall) begin
        expected_locations.push_back(locate_level(layer_index, mip_index));
        have_req = 0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_WIDTH:  tex_width = cfg_data;
          REG_BASE_HEIGHT: tex_height = cfg_data;
          REG_BASE_DEPTH:  tex_depth = cfg_data[DEPTH_W-1:0];
          REG_BPP:         tex_bpp = cfg_data[BPP_W-1:0];
          REG_MIP_COUNT:   tex_mips = cfg_data[MIP_W-1:0];
          default: ;
        endcase
        have_req = 0;
      end
      if (!have_req && pending_requests.size() > 0) begin
        cur_req = pending_requests.pop_front();
        have_req = 1;
        gap_left = cur_req.gap;
        settle_left = 3;
      end
      offer_item = 0;
      offer_write = 0;
      if (have_req) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!cur_req.is_write) begin
          offer_item = 1;
        end else if (expected_locations.size() == 0 && !out_valid) begin
          // block idle: let it settle before touching a register
          if (settle_left > 0) settle_left--;
          else offer_write = 1;
        end
      end
      in_valid <= offer_item;
      cfg_valid <= offer_write;
      if (offer_item) begin
        layer_index <= cur_req.layer;
        mip_index <= cur_req.mip;
      end
      if (offer_write) begin
        cfg_index <= cur_req.idx;
        cfg_data <= cur_req.data;
      end
    end
  end

  // monitor: check results in order and draw result stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_locations.size() == 0) begin
          note_error("result with no lookup outstanding");
        end else begin
          want = expected_locations.pop_front();
          if (level_width !== want.width)
            note_error($sformatf("level_width %0d, expected %0d", level_width, want.width));
          if (level_height !== want.height)
            note_error($sformatf("level_height %0d, expected %0d", level_height, want.height));
          if (level_depth !== want.depth)
            note_error($sformatf("level_depth %0d, expected %0d", level_depth, want.depth));
          if (level_bytes !== want.bytes)
            note_error($sformatf("level_bytes %0h, expected %0h", level_bytes, want.bytes));
          if (byte_offset !== want.offset)
            note_error($sformatf("byte_offset %0h, expected %0h", byte_offset, want.offset));
          if (overflow !== want.ovf)
            note_error($sformatf("overflow %0b, expected %0b", overflow, want.ovf));
        end
        n_received++;
        // long hold now and then so the block backs up into its input
        if (n_received % 150 == 100) stall_left = LONG_HOLD;
        else if ((n_received / 40) % 3 == 2) stall_left = 0;
        else stall_left = $urandom_range(0, 5);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // stimulus and end of test
  initial begin
    // reset values
    add_item(0, 0);
    add_item(2047, 15);
    add_item(1, 1);
    add_item(5, 0);

    // all zero: floor of one, no bytes, empty chain; spare index ignored
    add_write(REG_BASE_WIDTH, 0);
    add_write(REG_BASE_HEIGHT, 0);
    add_write(REG_BASE_DEPTH, 0);
    add_write(REG_BPP, 0);
    add_write(REG_MIP_COUNT, 0);
    add_write(REG_SPARE_FIRST, 32'h7FFF);
    add_item(0, 0);
    add_item(2047, 15);
    add_item(3, 2);

    // every register bit set: upper data bits dropped, heavy wrap
    add_write(REG_BASE_WIDTH, 32'h7FFF);
    add_write(REG_BASE_HEIGHT, 32'h7FFF);
    add_write(REG_BASE_DEPTH, 32'h7FFF);
    add_write(REG_BPP, 32'h7FFF);
    add_write(REG_MIP_COUNT, 32'h7FFF);
    add_write(REG_SPARE_LAST, 0);
    add_item(0, 0);
    add_item(2047, 15);
    add_item(1, 0);
    add_item(0, 15);
    add_item(2047, 14);

    // nominal maxima
    add_write(REG_BASE_WIDTH, 16384);
    add_write(REG_BASE_HEIGHT, 16384);
    add_write(REG_BASE_DEPTH, 2048);
    add_write(REG_BPP, 16);
    add_write(REG_MIP_COUNT, 15);
    add_item(2047, 0);
    add_item(0, 1);
    add_item(1, 15);

    // plain 2D texture; levels at and past the stored count
    add_write(REG_BASE_WIDTH, 256);
    add_write(REG_BASE_HEIGHT, 128);
    add_write(REG_BASE_DEPTH, 1);
    add_write(REG_BPP, 4);
    add_write(REG_MIP_COUNT, 9);
    add_write(CFG_IDX_W'(REG_SPARE_FIRST + 1), 32'h1234);
    add_item(0, 8);
    add_item(0, 9);
    add_item(2, 12);
    add_item(2047, 9);
    add_item(1, 0);
    add_item(7, 5);

    // random settings, each followed by a batch of lookups
    for (int p = 0; p < 14; p++) begin
      add_write(REG_BASE_WIDTH, $urandom_range(0, 32767) >> $urandom_range(0, 14));
      add_write(REG_BASE_HEIGHT, $urandom_range(0, 32767) >> $urandom_range(0, 14));
      add_write(REG_BASE_DEPTH, $urandom_range(0, 32767) >> $urandom_range(0, 14));
      add_write(REG_BPP, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                    : $urandom_range(0, 17));
      add_write(REG_MIP_COUNT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                          : $urandom_range(0, 15));
      if ($urandom_range(0, 2) == 0)
        add_write(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  $urandom_range(0, 32767));
      for (int k = 0; k < 50; k++)
        add_item(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 2047),
                 $urandom_range(0, 15));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() > 0 || have_req || expected_locations.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 400000);
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: mip_chain_buffer_offset_unit.f
+incdir+rtl
rtl/mcbo_pkg.sv
rtl/mcbo_mul.sv
rtl/mip_chain_buffer_offset_unit.sv
dv/tb_mip_chain_buffer_offset_unit.sv
